FILE: rtl/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// i2cbm_pkg: shared types and constants of the i2c bit level master
// transaction formats, command and phase codes, register map and reset values
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbm_pkg;

    // default width of the bus timing counter
    localparam int COUNTER_WIDTH_DEFAULT = 12;

    // entries in the queue between the front and the engine
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 8;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DELAY_UNIT  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACK_TIMEOUT = 2'd1;

    // register reset values
    localparam logic [7:0] DELAY_UNIT_RESET  = 8'd10;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    // bus commands
    typedef enum logic [2:0] {
        ACT_START = 3'd0,
        ACT_STOP  = 3'd1,
        ACT_WRITE = 3'd2,
        ACT_READ  = 3'd3,
        ACT_WAIT  = 3'd4,
        ACT_ACK   = 3'd5
    } action_t;

    // sequencer phases
    typedef enum logic [15:0] {
        PH_IDLE    = 16'h0001,
        PH_ST_A    = 16'h0002,
        PH_ST_B    = 16'h0004,
        PH_SP_A    = 16'h0008,
        PH_SP_B    = 16'h0010,
        PH_SP_C    = 16'h0020,
        PH_WR_LOW  = 16'h0040,
        PH_WR_HIGH = 16'h0080,
        PH_WR_FALL = 16'h0100,
        PH_RD_LOW  = 16'h0200,
        PH_RD_HIGH = 16'h0400,
        PH_AK_LOW  = 16'h0800,
        PH_AK_HIGH = 16'h1000,
        PH_WA_REL  = 16'h2000,
        PH_WA_RISE = 16'h4000,
        PH_WA_POLL = 16'h8000
    } phase_t;

    // input transaction
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } in_item_t;

    // output transaction
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } out_item_t;

    // classified tick held in the queue
    typedef struct packed {
        logic       cmd;
        action_t    kind;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_t;

    // queue status towards the engine
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // configuration registers
    typedef struct packed {
        logic [7:0] delay_unit_ticks;
        logic [7:0] ack_timeout;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/i2c_bit_level_master.sv
// ----------------------------------------------------------------------------
// i2c_bit_level_master: i2c master bit engine
// each input transaction is one bus tick, each output transaction the line
// levels and status after that tick
// ----------------------------------------------------------------------------
// One input transaction is taken every clock cycle while the queue has room,
// giving exactly one output transaction: the front classifies the tick into a
// two-entry queue, and the bus sequencer steps its phase machine once per tick
// into an output register. The sustained rate of one tick per cycle, set by
// that sequencer step, holds while the output side does not stall. Bus timing
// counts ticks, in units of the delay unit register; the user must write the
// configuration registers only while no tick is in flight (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bit_level_master #(
    parameter int COUNTER_WIDTH = i2cbm_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         in_valid,
    output logic                                        in_ready,
    input  var i2cbm_pkg::in_item_t                     in_data,
    output logic                                        out_valid,
    input  wire                                         out_ready,
    output i2cbm_pkg::out_item_t                        out_data,
    input  wire                                         cfg_we,
    input  wire [i2cbm_pkg::CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  wire [i2cbm_pkg::CFG_DATA_WIDTH-1:0]         cfg_wdata
);

    i2cbm_pkg::cfg_t      cfg_reg;
    i2cbm_pkg::tick_t     push_tick;
    i2cbm_pkg::tick_t     pop_tick;
    i2cbm_pkg::q_status_t q_status;
    logic                 push;
    logic                 pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay_unit_ticks <= i2cbm_pkg::DELAY_UNIT_RESET;
            cfg_reg.ack_timeout      <= i2cbm_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2cbm_pkg::REG_DELAY_UNIT:  cfg_reg.delay_unit_ticks <= cfg_wdata[7:0];
                i2cbm_pkg::REG_ACK_TIMEOUT: cfg_reg.ack_timeout      <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // tick intake
    i2cbm_front u_front (
        .in_data  (in_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_status (q_status),
        .push     (push),
        .tick     (push_tick)
    );

    // queue between intake and sequencer
    i2cbm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_tick),
        .pop       (pop),
        .pop_data  (pop_tick),
        .q_status  (q_status)
    );

    // bus sequencer
    i2cbm_engine #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .tick      (pop_tick),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    // the sequencer only steps on a queued tick
    a_pop_needs_tick : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("sequencer stepped on an empty queue");

    // the queue is never full and empty at once
    a_queue_status : assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

    // a stalled result holds the sequencer
    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !pop)
        else $error("sequencer stepped while a result was stalled");

    // a completing command leaves the engine idle
    a_done_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.done_res && out_data.busy_res))
        else $error("done reported while still busy");
`endif

endmodule

`default_nettype wire

FILE: rtl/i2cbm_front.sv
// ----------------------------------------------------------------------------
// i2cbm_front: tick intake
// accepts input transactions while the queue has room and classifies the
// command they carry
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_front (
    input  var i2cbm_pkg::in_item_t  in_data,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  var i2cbm_pkg::q_status_t q_status,
    output logic                     push,
    output i2cbm_pkg::tick_t         tick
);

    // handshake towards the queue
    assign in_ready = !q_status.full;
    assign push     = in_valid && !q_status.full;

    // command classification, unknown actions count as no command
    always_comb
    begin
        tick.cmd      = in_data.cmd_valid && (in_data.action <= i2cbm_pkg::ACT_ACK);
        tick.kind     = i2cbm_pkg::action_t'(in_data.action);
        tick.tx_byte  = in_data.tx_byte;
        tick.send_ack = in_data.send_ack;
        tick.sda_in   = in_data.sda_in;
    end

endmodule

`default_nettype wire

FILE: rtl/i2cbm_queue.sv
// ----------------------------------------------------------------------------
// i2cbm_queue: tick queue
// short first-in first-out queue of classified ticks between front and engine
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_queue (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push,
    input  var i2cbm_pkg::tick_t     push_data,
    input  wire                      pop,
    output i2cbm_pkg::tick_t         pop_data,
    output i2cbm_pkg::q_status_t     q_status
);

    localparam int DEPTH   = i2cbm_pkg::QUEUE_DEPTH;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR   = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    i2cbm_pkg::tick_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data       = entry_reg[rd_ptr_reg];
    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == FULL_COUNT);

endmodule

`default_nettype wire

FILE: rtl/i2cbm_engine.sv
// ----------------------------------------------------------------------------
// i2cbm_engine: bus sequencer
// steps the scl/sda phase machine by one tick per queued transaction and
// registers the resulting line levels and status
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_engine #(
    parameter int COUNTER_WIDTH = i2cbm_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  var i2cbm_pkg::cfg_t      cfg,
    input  var i2cbm_pkg::tick_t     tick,
    input  var i2cbm_pkg::q_status_t q_status,
    output logic                     pop,
    output logic                     out_valid,
    input  wire                      out_ready,
    output i2cbm_pkg::out_item_t     out_data
);

    localparam int CW = COUNTER_WIDTH;

    i2cbm_pkg::phase_t phase_reg, phase_next;
    logic [3:0]        bit_count_reg, bit_count_next;
    logic [CW-1:0]     delay_reg, delay_next;
    logic [7:0]        shift_reg, shift_next;
    logic [7:0]        poll_reg, poll_next;
    logic [7:0]        received_reg, received_next;
    logic              ack_fail_reg, ack_fail_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              pending_ack_reg, pending_ack_next;
    logic              done;

    logic              out_valid_reg, out_valid_next;
    i2cbm_pkg::out_item_t out_data_reg, result;

    logic [7:0]        unit_ticks;
    logic [CW-1:0]     ticks_1u, ticks_2u, ticks_4u;
    logic [3:0]        bit_inc;
    logic [7:0]        shift_in;

    // one step per tick when the result slot is free or being taken
    assign pop = !q_status.empty && (!out_valid_reg || out_ready);

    // segment lengths, a zero unit counts as one tick
    assign unit_ticks = (cfg.delay_unit_ticks == 8'd0) ? 8'd1 : cfg.delay_unit_ticks;
    assign ticks_1u   = CW'(unit_ticks);
    assign ticks_2u   = CW'({unit_ticks, 1'b0});
    assign ticks_4u   = CW'({unit_ticks, 2'b00});
    assign bit_inc    = bit_count_reg + 4'd1;
    assign shift_in   = {shift_reg[6:0], tick.sda_in};

    // phase machine
    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        delay_next       = delay_reg;
        shift_next       = shift_reg;
        poll_next        = poll_reg;
        received_next    = received_reg;
        ack_fail_next    = ack_fail_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        pending_ack_next = pending_ack_reg;
        done             = 1'b0;

        case (phase_reg)
            i2cbm_pkg::PH_IDLE:
            begin
                if (tick.cmd)
                begin
                    case (tick.kind)
                        i2cbm_pkg::ACT_START:
                        begin
                            sda_next   = 1'b1;
                            scl_next   = 1'b1;
                            phase_next = i2cbm_pkg::PH_ST_A;
                            delay_next = ticks_4u;
                        end
                        i2cbm_pkg::ACT_STOP:
                        begin
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            phase_next = i2cbm_pkg::PH_SP_A;
                            delay_next = ticks_4u;
                        end
                        i2cbm_pkg::ACT_WRITE:
                        begin
                            scl_next       = 1'b0;
                            bit_count_next = 4'd0;
                            sda_next       = tick.tx_byte[7];
                            shift_next     = {tick.tx_byte[6:0], 1'b0};
                            phase_next     = i2cbm_pkg::PH_WR_LOW;
                            delay_next     = ticks_2u;
                        end
                        i2cbm_pkg::ACT_READ:
                        begin
                            scl_next         = 1'b0;
                            sda_next         = 1'b1;
                            bit_count_next   = 4'd0;
                            shift_next       = 8'd0;
                            pending_ack_next = tick.send_ack;
                            phase_next       = i2cbm_pkg::PH_RD_LOW;
                            delay_next       = ticks_2u;
                        end
                        i2cbm_pkg::ACT_WAIT:
                        begin
                            ack_fail_next = 1'b0;
                            sda_next      = 1'b1;
                            poll_next     = 8'd0;
                            phase_next    = i2cbm_pkg::PH_WA_REL;
                            delay_next    = ticks_1u;
                        end
                        default:
                        begin
                            // lone ack or nack
                            scl_next         = 1'b0;
                            sda_next         = !tick.send_ack;
                            pending_ack_next = tick.send_ack;
                            phase_next       = i2cbm_pkg::PH_AK_LOW;
                            delay_next       = ticks_2u;
                        end
                    endcase
                end
            end

            i2cbm_pkg::PH_WA_POLL:
            begin
                // acknowledge poll, timeout falls into a stop sequence
                if (!tick.sda_in)
                begin
                    scl_next   = 1'b0;
                    phase_next = i2cbm_pkg::PH_IDLE;
                    delay_next = '0;
                    done       = 1'b1;
                end
                else if (poll_reg >= cfg.ack_timeout)
                begin
                    ack_fail_next = 1'b1;
                    scl_next      = 1'b0;
                    sda_next      = 1'b0;
                    phase_next    = i2cbm_pkg::PH_SP_A;
                    delay_next    = ticks_4u;
                end
                else
                begin
                    poll_next = poll_reg + 8'd1;
                end
            end

            default:
            begin
                if (delay_reg > CW'(1))
                begin
                    delay_next = delay_reg - CW'(1);
                end
                else
                begin
                    // segment ends, move to the next one
                    case (phase_reg)
                        i2cbm_pkg::PH_ST_A:
                        begin
                            sda_next   = 1'b0;
                            phase_next = i2cbm_pkg::PH_ST_B;
                            delay_next = ticks_4u;
                        end
                        i2cbm_pkg::PH_ST_B:
                        begin
                            scl_next   = 1'b0;
                            phase_next = i2cbm_pkg::PH_IDLE;
                            delay_next = '0;
                            done       = 1'b1;
                        end
                        i2cbm_pkg::PH_SP_A:
                        begin
                            scl_next   = 1'b1;
                            phase_next = i2cbm_pkg::PH_SP_B;
                            delay_next = CW'(1);
                        end
                        i2cbm_pkg::PH_SP_B:
                        begin
                            sda_next   = 1'b1;
                            phase_next = i2cbm_pkg::PH_SP_C;
                            delay_next = ticks_4u;
                        end
                        i2cbm_pkg::PH_WR_LOW:
                        begin
                            scl_next   = 1'b1;
                            phase_next = i2cbm_pkg::PH_WR_HIGH;
                            delay_next = ticks_2u;
                        end
                        i2cbm_pkg::PH_WR_HIGH:
                        begin
                            scl_next   = 1'b0;
                            phase_next = i2cbm_pkg::PH_WR_FALL;
                            delay_next = ticks_2u;
                        end
                        i2cbm_pkg::PH_WR_FALL:
                        begin
                            bit_count_next = bit_inc;
                            if (bit_inc[3])
                            begin
                                phase_next = i2cbm_pkg::PH_IDLE;
                                delay_next = '0;
                                done       = 1'b1;
                            end
                            else
                            begin
                                sda_next   = shift_reg[7];
                                shift_next = {shift_reg[6:0], 1'b0};
                                phase_next = i2cbm_pkg::PH_WR_LOW;
                                delay_next = ticks_2u;
                            end
                        end
                        i2cbm_pkg::PH_RD_LOW:
                        begin
                            scl_next   = 1'b1;
                            phase_next = i2cbm_pkg::PH_RD_HIGH;
                            delay_next = ticks_1u;
                        end
                        i2cbm_pkg::PH_RD_HIGH:
                        begin
                            // sample sda at the end of the high segment
                            shift_next     = shift_in;
                            bit_count_next = bit_inc;
                            scl_next       = 1'b0;
                            if (bit_inc[3])
                            begin
                                received_next = shift_in;
                                sda_next      = !pending_ack_reg;
                                phase_next    = i2cbm_pkg::PH_AK_LOW;
                                delay_next    = ticks_2u;
                            end
                            else
                            begin
                                phase_next = i2cbm_pkg::PH_RD_LOW;
                                delay_next = ticks_2u;
                            end
                        end
                        i2cbm_pkg::PH_AK_LOW:
                        begin
                            scl_next   = 1'b1;
                            phase_next = i2cbm_pkg::PH_AK_HIGH;
                            delay_next = ticks_2u;
                        end
                        i2cbm_pkg::PH_AK_HIGH:
                        begin
                            scl_next   = 1'b0;
                            sda_next   = 1'b1;
                            phase_next = i2cbm_pkg::PH_IDLE;
                            delay_next = '0;
                            done       = 1'b1;
                        end
                        i2cbm_pkg::PH_WA_REL:
                        begin
                            scl_next   = 1'b1;
                            phase_next = i2cbm_pkg::PH_WA_RISE;
                            delay_next = ticks_1u;
                        end
                        i2cbm_pkg::PH_WA_RISE:
                        begin
                            poll_next  = 8'd0;
                            phase_next = i2cbm_pkg::PH_WA_POLL;
                            delay_next = '0;
                        end
                        default:
                        begin
                            // end of stop sequence
                            phase_next = i2cbm_pkg::PH_IDLE;
                            delay_next = '0;
                            done       = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

    // result of this tick
    always_comb
    begin
        result.scl_out   = scl_next;
        result.sda_out   = sda_next;
        result.busy_res  = (phase_next != i2cbm_pkg::PH_IDLE);
        result.done_res  = done;
        result.rx_byte   = received_next;
        result.ack_error = ack_fail_next;
    end

    assign out_valid_next = pop || (out_valid_reg && !out_ready);

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= i2cbm_pkg::PH_IDLE;
            bit_count_reg   <= '0;
            delay_reg       <= '0;
            shift_reg       <= '0;
            poll_reg        <= '0;
            received_reg    <= '0;
            ack_fail_reg    <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            pending_ack_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg       <= phase_next;
                bit_count_reg   <= bit_count_next;
                delay_reg       <= delay_next;
                shift_reg       <= shift_next;
                poll_reg        <= poll_next;
                received_reg    <= received_next;
                ack_fail_reg    <= ack_fail_next;
                scl_reg         <= scl_next;
                sda_reg         <= sda_next;
                pending_ack_reg <= pending_ack_next;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
